@@ rtl/edf_periodic_task_scheduler_unit_defines.svh @@
// Assertion macros for the EDF scheduler RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef EDF_PERIODIC_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define EDF_PERIODIC_TASK_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define EDF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define EDF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/edf_pkg.sv @@
// Shared constants, item and control types for the EDF scheduler.
// No dependencies; every RTL module and interface imports this package.
`default_nettype none

package edf_pkg;

  localparam int MAX_TASKS  = 8;
  localparam int TIME_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_TASKS);
  localparam int CNT_W      = 4;
  localparam int SLOT_W     = 3;
  localparam int FLD_W      = 16;
  localparam int OUT_TW     = 32;
  localparam int CMP_W      = (IDX_W > CNT_W) ? ((IDX_W > SLOT_W) ? IDX_W : SLOT_W)
                                              : ((CNT_W > SLOT_W) ? CNT_W : SLOT_W);
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = APB_AW - 2;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ACTIVE_COUNT = REG_IDX_W'(0)
  } reg_idx_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SLOT_W-1:0] task_slot;
    logic [FLD_W-1:0]  first_arrival;
    logic [FLD_W-1:0]  work_ticks;
    logic [FLD_W-1:0]  relative_deadline;
    logic [FLD_W-1:0]  task_period;
  } in_item_t;

  typedef struct packed {
    logic [OUT_TW-1:0] tick_time;
    logic              is_idle;
    logic [SLOT_W-1:0] running_slot;
    logic              job_finished;
  } out_item_t;

  // Best candidate handed along the cell chain.
  typedef struct packed {
    logic                  valid;
    logic [TIME_WIDTH-1:0] due;
    logic [IDX_W-1:0]      idx;
  } best_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                  load;
    logic [SLOT_W-1:0]     slot;
    logic [FLD_W-1:0]      arrive;
    logic [FLD_W-1:0]      work;
    logic [FLD_W-1:0]      deadline;
    logic [FLD_W-1:0]      period;
    logic                  rel;
    logic [TIME_WIDTH-1:0] now;
    logic [CNT_W-1:0]      count;
    logic                  upd;
    logic                  fix;
    logic [IDX_W-1:0]      sel;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/edf_in_if.sv @@
// Input item channel: valid/ready handshake carrying one load or tick item.
// Depends on edf_pkg.
`default_nettype none

interface edf_in_if;
  import edf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/edf_out_if.sv @@
// Result item channel: valid/ready handshake carrying one schedule decision.
// Depends on edf_pkg.
`default_nettype none

interface edf_out_if;
  import edf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/edf_apb.sv @@
// APB register slave holding the active task count.
// Depends on edf_pkg.
`default_nettype none

module edf_apb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [edf_pkg::APB_AW-1:0]   paddr,
  input  logic [edf_pkg::APB_DW-1:0]   pwdata,
  output logic [edf_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [edf_pkg::CNT_W-1:0]    count_o
);
  import edf_pkg::*;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready
                   && (reg_idx == REG_ACTIVE_COUNT);

  always_comb begin
    count_d = count_q;
    if (wr_en) begin
      count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
    end else begin
      count_q <= count_d;
    end
  end

  assign prdata  = (psel && (reg_idx == REG_ACTIVE_COUNT)) ? APB_DW'(count_q) : '0;
  assign count_o = count_q;

endmodule

`default_nettype wire

@@ rtl/edf_cell.sv @@
// One task slot: stores the task's state and takes part in the deadline chain.
// Depends on edf_pkg.
`default_nettype none

module edf_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [edf_pkg::IDX_W-1:0] idx_i,
  input  edf_pkg::cell_ctl_t       ctl_i,
  input  edf_pkg::best_t           best_i,
  output edf_pkg::best_t           best_o,
  output logic                     fin_o
);
  import edf_pkg::*;

  logic                  alive_q, alive_d;
  best_t                 best_q, best_d;
  logic [TIME_WIDTH-1:0] release_q;
  logic [TIME_WIDTH-1:0] due_q;
  logic [FLD_W-1:0]      work_q;
  logic [FLD_W-1:0]      st_work_q;
  logic [FLD_W-1:0]      st_dl_q;
  logic [FLD_W-1:0]      st_per_q;

  logic active;
  logic hit_load;
  logic hit_sel;
  logic due_now;
  logic cand;

  assign active   = CMP_W'(idx_i) < CMP_W'(ctl_i.count);
  assign hit_load = ctl_i.load && (CMP_W'(ctl_i.slot) == CMP_W'(idx_i));
  assign hit_sel  = ctl_i.sel == idx_i;
  assign due_now  = release_q <= ctl_i.now;
  // Job ends on this tick when at most one unit of work is left.
  assign fin_o    = work_q <= FLD_W'(1);
  assign cand     = alive_q && active;

  always_comb begin
    alive_d = alive_q;
    if (hit_load) begin
      alive_d = 1'b0;
    end else if (ctl_i.rel && active && due_now) begin
      alive_d = 1'b1;
    end else if (ctl_i.upd && hit_sel && fin_o) begin
      alive_d = 1'b0;
    end
  end

  // Strict compare keeps the lower slot on a tie.
  always_comb begin
    best_d = best_i;
    if (cand && (!best_i.valid || (due_q < best_i.due))) begin
      best_d.valid = 1'b1;
      best_d.due   = due_q;
      best_d.idx   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
      best_q  <= '0;
    end else begin
      alive_q <= alive_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_load) begin
      st_work_q <= ctl_i.work;
      st_dl_q   <= ctl_i.deadline;
      st_per_q  <= ctl_i.period;
      work_q    <= ctl_i.work;
      release_q <= TIME_WIDTH'(ctl_i.arrive);
      due_q     <= TIME_WIDTH'(ctl_i.arrive) + TIME_WIDTH'(ctl_i.deadline);
    end else if (ctl_i.upd && hit_sel) begin
      if (fin_o) begin
        work_q    <= st_work_q;
        release_q <= release_q + TIME_WIDTH'(st_per_q);
      end else begin
        work_q <= work_q - FLD_W'(1);
      end
    end else if (ctl_i.fix && hit_sel) begin
      due_q <= release_q + TIME_WIDTH'(st_dl_q);
    end
  end

  assign best_o = best_q;

endmodule

`default_nettype wire

@@ rtl/edf_periodic_task_scheduler_unit.sv @@
// Top level of the EDF periodic task scheduler: sequencer, cell chain, APB.
// Depends on edf_pkg, edf_in_if, edf_out_if, edf_apb, edf_cell and the defines.
//
// Usage:
//  - in_i carries items. A load item (cmd = load) writes one task slot's
//    arrival, work, relative deadline and period and yields no result. A
//    tick item yields exactly one result on res_o: the current time, the
//    slot that ran (or idle) and whether its job finished.
//  - The APB port holds the active task count at byte address 0; write it
//    only while the block is idle. pready is always high.
//  - A tick releases due tasks in its accept cycle, then walks the best
//    deadline along a chain of MAX_TASKS registered cells, one cell a cycle.
//    The update state then registers the result and applies the run, and
//    the fix state recomputes the deadline; no new item is taken until the
//    block is back in idle. A load item is taken every cycle.
//  - The result register parts the two sides: a new item is taken while a
//    result waits. If the receiver stalls, the next tick holds before its
//    update step until the waiting result is taken.
//  - Reset clears time, all alive flags and the result valid flag, and sets
//    the active count to one. Task slots must be loaded before they take part.
`default_nettype none

`include "edf_periodic_task_scheduler_unit_defines.svh"

module edf_periodic_task_scheduler_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  edf_in_if.sink                     in_i,
  edf_out_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [edf_pkg::APB_AW-1:0] paddr,
  input  logic [edf_pkg::APB_DW-1:0] pwdata,
  output logic [edf_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import edf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_FIX  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      scan_q, scan_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic                  fix_q, fix_d;
  logic [IDX_W-1:0]      sel_q, sel_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic [CNT_W-1:0] count;
  cell_ctl_t        ctl;
  best_t            link [MAX_TASKS+1];
  logic             fin_vec [MAX_TASKS];
  best_t            winner;
  logic             win_fin;
  logic             in_acc;
  logic             out_free;
  logic             out_load;

  edf_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .count_o (count)
  );

  // Accept only between ticks; the result register stays independent.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || res_o.ready;
  assign out_load   = (state_q == ST_UPD) && out_free;

  // Broadcast to the cells.
  always_comb begin
    ctl.load     = in_acc && (in_i.data.cmd == CMD_LOAD);
    ctl.slot     = in_i.data.task_slot;
    ctl.arrive   = in_i.data.first_arrival;
    ctl.work     = in_i.data.work_ticks;
    ctl.deadline = in_i.data.relative_deadline;
    ctl.period   = in_i.data.task_period;
    ctl.rel      = in_acc && (in_i.data.cmd == CMD_TICK);
    ctl.now      = now_q;
    ctl.count    = count;
    ctl.upd      = out_load && winner.valid;
    ctl.fix      = (state_q == ST_FIX) && fix_q;
    ctl.sel      = (state_q == ST_FIX) ? sel_q : winner.idx;
  end

  // Chain head carries no candidate.
  assign link[0] = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    edf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .ctl_i  (ctl),
      .best_i (link[g]),
      .best_o (link[g+1]),
      .fin_o  (fin_vec[g])
    );
  end

  assign winner = link[MAX_TASKS];

  // Pick the winner's finish flag.
  always_comb begin
    win_fin = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (winner.idx == IDX_W'(i)) begin
        win_fin = fin_vec[i];
      end
    end
    win_fin = win_fin && winner.valid;
  end

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    now_d       = now_q;
    fix_d       = fix_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // Drop the waiting result once taken.
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (ctl.rel) begin
          state_d = ST_SCAN;
          scan_d  = '0;
        end
      end
      ST_SCAN: begin
        // Advance one cell a cycle until the last cell holds the winner.
        if (scan_q == IDX_W'(MAX_TASKS - 1)) begin
          state_d = ST_UPD;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      ST_UPD: begin
        // Hold until the result register is free.
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.tick_time    = OUT_TW'(now_q);
          out_d.is_idle      = !winner.valid;
          out_d.running_slot = winner.valid ? SLOT_W'(winner.idx) : '0;
          out_d.job_finished = win_fin;
          now_d              = now_q + TIME_WIDTH'(1);
          sel_d              = winner.idx;
          fix_d              = win_fin;
          state_d            = ST_FIX;
        end
      end
      ST_FIX: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      now_q       <= '0;
      fix_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      now_q       <= now_d;
      fix_q       <= fix_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    out_q <= out_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  `EDF_ASSERT_NXT(a_now_adv, out_load, now_q == TIME_WIDTH'($past(now_q) + 1'b1), "time did not advance with result")
  `EDF_ASSERT_IMP(a_fix_after_upd, state_q == ST_FIX, $past(state_q) == ST_UPD, "deadline fix without update")
  `EDF_ASSERT_IMP(a_fin_not_idle, out_valid_q, !(out_q.is_idle && out_q.job_finished), "idle tick reports finish")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the EDF periodic task scheduler unit.
// Depends on edf_pkg, edf_in_if, edf_out_if and the scheduler top level.
// Holds its own deadline predictor and checks every schedule decision in order.
`timescale 1ns / 1ps

module tb_top;
  import edf_pkg::*;

  // Longest run of cycles with no item moving on either channel.
  localparam int IDLE_LIMIT    = 3000;
  // Cycles to let the last tick finish its deadline step before a register write.
  localparam int SETTLE_CYCLES = MAX_TASKS + 4;
  // Length of the deliberate receiver hold-off.
  localparam int HOLD_CYCLES   = 400;

  typedef enum int {
    SINK_STEADY,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_SPARSE
  } sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  edf_in_if  in_ch ();
  edf_out_if res_ch ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Predicted scheduler state, advanced once per accepted item.
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] release_t   [MAX_TASKS];
  logic [TIME_WIDTH-1:0] deadline_t  [MAX_TASKS];
  logic [FLD_W-1:0]      work_left_t [MAX_TASKS];
  logic [FLD_W-1:0]      job_work    [MAX_TASKS];
  logic [FLD_W-1:0]      job_deadline[MAX_TASKS];
  logic [FLD_W-1:0]      job_period  [MAX_TASKS];
  logic                  released    [MAX_TASKS];
  logic [CNT_W-1:0]      slot_count;

  // Schedule decisions still owed by the block, oldest first.
  out_item_t pending_decisions[$];

  int error_count  = 0;
  int burst_left   = 0;
  int hold_asked   = 0;
  int quiet_cycles = 0;

  edf_periodic_task_scheduler_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("tb_top: %s mismatch at %0t: got 0x%0h, expected 0x%0h",
             what, $realtime, got, want);
  endtask

  // Advance the predictor by one item. A load rewrites one slot and starts its
  // first job; a tick releases due slots, runs the earliest deadline (lowest
  // index wins a tie) and queues the decision.
  task automatic schedule_step(input in_item_t it);
    int s;
    int n;
    int pick;
    out_item_t d;
    if (it.cmd == CMD_LOAD) begin
      s = int'(it.task_slot);
      job_work[s]     = it.work_ticks;
      job_deadline[s] = it.relative_deadline;
      job_period[s]   = it.task_period;
      release_t[s]    = TIME_WIDTH'(it.first_arrival);
      work_left_t[s]  = it.work_ticks;
      deadline_t[s]   = TIME_WIDTH'(it.first_arrival) + TIME_WIDTH'(it.relative_deadline);
      released[s]     = 1'b0;
    end else begin
      // Counts above the slot total saturate.
      n = (int'(slot_count) > MAX_TASKS) ? MAX_TASKS : int'(slot_count);
      pick = -1;
      for (int i = 0; i < n; i++)
        if (release_t[i] <= now_t) released[i] = 1'b1;
      for (int i = 0; i < n; i++)
        if (released[i] && (pick < 0 || deadline_t[i] < deadline_t[pick])) pick = i;
      d = '0;
      d.tick_time = OUT_TW'(now_t);
      d.is_idle   = (pick < 0);
      if (pick >= 0) begin
        d.running_slot = SLOT_W'(pick);
        // Zero work saturates, so such a job finishes after a single tick.
        if (work_left_t[pick] != '0) work_left_t[pick]--;
        if (work_left_t[pick] == '0) begin
          d.job_finished     = 1'b1;
          released[pick]     = 1'b0;
          work_left_t[pick]  = job_work[pick];
          release_t[pick]    = release_t[pick] + TIME_WIDTH'(job_period[pick]);
          deadline_t[pick]   = release_t[pick] + TIME_WIDTH'(job_deadline[pick]);
        end
      end
      pending_decisions.push_back(d);
      now_t = now_t + 1'b1;
    end
  endtask

  function automatic in_item_t make_item(input cmd_e c, input int slot, input int arr,
                                         input int work, input int dl, input int per);
    in_item_t it;
    it.cmd               = c;
    it.task_slot         = SLOT_W'(slot);
    it.first_arrival     = FLD_W'(arr);
    it.work_ticks        = FLD_W'(work);
    it.relative_deadline = FLD_W'(dl);
    it.task_period       = FLD_W'(per);
    return it;
  endfunction

  // Mostly well-formed task sets released close to the current time, with a
  // tenth of loads drawn over the whole field range.
  function automatic in_item_t random_item(input int load_pct);
    in_item_t it;
    it = make_item(CMD_TICK, $urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 99) < load_pct) begin
      it.cmd = CMD_LOAD;
      if ($urandom_range(0, 9) != 0) begin
        it.first_arrival     = FLD_W'(now_t + $urandom_range(0, 24));
        it.work_ticks        = ($urandom_range(0, 19) == 0) ? '0 : FLD_W'($urandom_range(1, 5));
        it.relative_deadline = FLD_W'($urandom_range(0, 40));
        it.task_period       = ($urandom_range(0, 19) == 0) ? '0 : FLD_W'($urandom_range(2, 40));
      end
    end
    return it;
  endfunction

  // Offer one item in bursts of random length, drop valid for a random gap
  // between bursts, and predict once the item is taken.
  task automatic offer_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    burst_left--;
    schedule_step(it);
  endtask

  // Hold the input, wait for every owed decision, then give the last tick
  // time to finish its deadline step.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the active task count, then read it straight back.
  task automatic write_slot_count(input logic [CNT_W-1:0] v);
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE_COUNT, 2'b00};
    pwdata  <= APB_DW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    slot_count = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd != APB_DW'(v)) report_mismatch("active_task_count readback", rd, APB_DW'(v));
  endtask

  // Reset count of one: slot 0 with zero work and zero period finishes a job
  // every tick and is released again at once. Every slot gets loaded here so
  // that no later count can reach an unwritten slot.
  task automatic test_reset_count_and_zero_work();
    offer_item(make_item(CMD_LOAD, 0, 0, 0, 0, 0));
    for (int i = 1; i < MAX_TASKS; i++)
      offer_item(make_item(CMD_LOAD, i, i - 1, 2, 6, 10));
    repeat (3) offer_item(make_item(CMD_TICK, 0, 0, 0, 0, 0));
    settle_block();
  endtask

  // Full slot set: an all-ones load that is never released, two slots tied on
  // deadline (lower index must win) and a huge job with the latest deadline among released slots.
  task automatic test_full_set_and_ties();
    write_slot_count(CNT_W'(MAX_TASKS));
    offer_item(make_item(CMD_LOAD, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_item(make_item(CMD_LOAD, 1, 3, 2, 5, 8));
    offer_item(make_item(CMD_LOAD, 2, 3, 1, 5, 8));
    offer_item(make_item(CMD_LOAD, 3, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    repeat (6) offer_item(make_item(CMD_TICK, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    settle_block();
  endtask

  // Count of zero idles every tick; a count above the slot total saturates.
  task automatic test_count_extremes();
    write_slot_count('0);
    repeat (2) offer_item(make_item(CMD_TICK, 0, 0, 0, 0, 0));
    settle_block();
    write_slot_count('1);
    repeat (2) offer_item(make_item(CMD_TICK, 0, 0, 0, 0, 0));
    settle_block();
  endtask

  // Ask the receiver for a long hold-off while items keep coming, so the
  // result register fills and the input stalls.
  task automatic test_receiver_backpressure();
    write_slot_count(CNT_W'(MAX_TASKS));
    hold_asked++;
    repeat (60) offer_item(random_item(30));
    settle_block();
  endtask

  // Random task sets under a sequence of counts, extremes included.
  task automatic test_random_phases();
    int counts[6];
    counts = '{1, MAX_TASKS, 0, 15, 5, $urandom_range(1, MAX_TASKS)};
    foreach (counts[p]) begin
      write_slot_count(CNT_W'(counts[p]));
      repeat (95) offer_item(random_item(25));
      settle_block();
    end
  endtask

  // Result side: check each decision against the oldest prediction and stall
  // on a randomly chosen pattern, or for a hold-off when a test asks for one.
  initial begin : result_sink
    sink_mode_e mode;
    int mode_left;
    int hold_left;
    int hold_seen;
    int phase;
    out_item_t got;
    out_item_t want;
    mode      = SINK_STEADY;
    mode_left = 100;
    hold_left = 0;
    hold_seen = 0;
    phase     = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (pending_decisions.size() == 0) begin
          report_mismatch("unpredicted decision, tick_time", got.tick_time, '0);
        end else begin
          want = pending_decisions.pop_front();
          if (got.tick_time != want.tick_time)
            report_mismatch("tick_time", got.tick_time, want.tick_time);
          if (got.is_idle != want.is_idle)
            report_mismatch("is_idle", got.is_idle, want.is_idle);
          if (got.running_slot != want.running_slot)
            report_mismatch("running_slot", got.running_slot, want.running_slot);
          if (got.job_finished != want.job_finished)
            report_mismatch("job_finished", got.job_finished, want.job_finished);
        end
      end
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      phase = (phase + 1) % 5;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_STEADY:  res_ch.ready <= 1'b1;
          SINK_RANDOM:  res_ch.ready <= ($urandom_range(0, 99) < 60);
          SINK_PATTERN: res_ch.ready <= (phase >= 2);
          default:      res_ch.ready <= (phase == 0);
        endcase
      end
    end
  end

  // Count cycles in which no item moves on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    now_t       = '0;
    slot_count  = CNT_RESET;
    for (int i = 0; i < MAX_TASKS; i++) begin
      released[i]     = 1'b0;
      release_t[i]    = '0;
      deadline_t[i]   = '0;
      work_left_t[i]  = '0;
      job_work[i]     = '0;
      job_deadline[i] = '0;
      job_period[i]   = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_count_and_zero_work();
    test_full_set_and_ties();
    test_count_extremes();
    test_receiver_backpressure();
    test_random_phases();

    if (error_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/edf_pkg.sv
rtl/edf_in_if.sv
rtl/edf_out_if.sv
rtl/edf_apb.sv
rtl/edf_cell.sv
rtl/edf_periodic_task_scheduler_unit.sv
tb/tb_top.sv
